/* sv/lfsa_pkg.sv */
// Shared types and constants for the lowest free slot lease allocator.
package lfsa_pkg;

  localparam int SLOTS_DEFAULT = 256;
  localparam int CNT_W         = 9;
  localparam int TIME_W        = 30;
  localparam int REL_W         = 31;
  localparam int TOTAL_W       = 48;
  localparam int IDX_OUT_W     = 8;

  localparam logic [CNT_W-1:0]   CNT_RESET = 9'd256;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // Request fields as they arrive on the input channel
  typedef struct packed {
    logic [TIME_W-1:0] req_time;
    logic [TIME_W-1:0] amount;
    logic [TIME_W-1:0] hold_time;
  } lfsa_in_t;

  // Result fields as they leave on the output channel
  typedef struct packed {
    logic                 granted;
    logic [IDX_OUT_W-1:0] slot_index;
    logic [TOTAL_W-1:0]   slot_total;
  } lfsa_out_t;

  // Request plus partial result, handed from cell to cell
  typedef struct packed {
    logic [TIME_W-1:0]  req_time;
    logic [TIME_W-1:0]  amount;
    logic [TIME_W-1:0]  hold_time;
    logic               granted;
    logic [TOTAL_W-1:0] slot_total;
  } lfsa_item_t;

endpackage

/* sv/lowest_free_slot_lease_allocator.sv */
// Top level: a chain of slot cells that each request walks through in order.
//
//   port group | direction | handshake          | contents
//   in_        | input     | in_valid/in_stall  | lfsa_in_t: req_time, amount, hold_time
//   out_       | output    | out_valid/out_stall| lfsa_out_t: granted, slot_index, slot_total
//   cfg_       | input     | cfg_wr_en          | slot_count
//
// A request advances one cell per cycle unless a stalled result holds the chain; out_valid
// is the last cell's registered valid, so each request is registered once in every cell.
// With no stall the chain takes one transfer per cycle.
// Each cell holds one slot and one request stage.
// Reset clears leases and totals in every cell at once; no clearing pass.
// While a result waits under out_stall the whole chain holds and in_stall is raised.
module lowest_free_slot_lease_allocator #(
  parameter int SLOTS = lfsa_pkg::SLOTS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  lfsa_pkg::lfsa_in_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output lfsa_pkg::lfsa_out_t         out_data,
  input  logic                        cfg_wr_en,
  input  logic [lfsa_pkg::CNT_W-1:0]  cfg_wr_data
);

  localparam int IDX_W = $clog2(SLOTS);

  logic [lfsa_pkg::CNT_W-1:0] slot_count_r;
  logic                       en;
  logic                       chain_valid [SLOTS+1];
  lfsa_pkg::lfsa_item_t       chain_item  [SLOTS+1];
  logic [IDX_W-1:0]           chain_idx   [SLOTS+1];
  logic [IDX_W+7:0]           idx_ext;

  // slot count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r <= lfsa_pkg::CNT_RESET;
    end else if (cfg_wr_en) begin
      slot_count_r <= cfg_wr_data;
    end
  end

  // chain moves unless the last stage holds a stalled result
  assign en       = !chain_valid[SLOTS] || !out_stall;
  assign in_stall = !en;

  // request enters with no grant yet: request fields, then granted and total cleared
  assign chain_valid[0] = in_valid;
  assign chain_item[0]  = {in_data, 1'b0, {lfsa_pkg::TOTAL_W{1'b0}}};
  assign chain_idx[0]   = '0;

  // one cell per slot, lowest index first
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    lfsa_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (g)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (en),
      .slot_count (slot_count_r),
      .valid_i    (chain_valid[g]),
      .item_i     (chain_item[g]),
      .idx_i      (chain_idx[g]),
      .valid_o    (chain_valid[g+1]),
      .item_o     (chain_item[g+1]),
      .idx_o      (chain_idx[g+1])
    );
  end

  // last cell stage is the output register
  assign idx_ext             = (IDX_W + 8)'(chain_idx[SLOTS]);
  assign out_valid           = chain_valid[SLOTS];
  assign out_data.granted    = chain_item[SLOTS].granted;
  assign out_data.slot_index = idx_ext[7:0];
  assign out_data.slot_total = chain_item[SLOTS].slot_total;

  // refusal carries zero index and total
  a_refuse_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.granted |-> out_data.slot_index == '0 && out_data.slot_total == '0)
    else $error("refused request carries nonzero fields");

  // a stalled result is held by the frozen chain
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // input is held off only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with no waiting result");

endmodule

/* sv/lfsa_cell.sv */
// One slot of the allocator chain: lease state, total, and one request stage.
module lfsa_cell #(
  parameter int IDX_W    = 8,
  parameter int CELL_IDX = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic [lfsa_pkg::CNT_W-1:0]    slot_count,
  input  logic                          valid_i,
  input  lfsa_pkg::lfsa_item_t          item_i,
  input  logic [IDX_W-1:0]              idx_i,
  output logic                          valid_o,
  output lfsa_pkg::lfsa_item_t          item_o,
  output logic [IDX_W-1:0]              idx_o
);

  localparam int CMP_W = (IDX_W + 1 > lfsa_pkg::CNT_W) ? IDX_W + 1 : lfsa_pkg::CNT_W;

  logic                          busy_r, busy_nxt;
  logic [lfsa_pkg::REL_W-1:0]    rel_r, rel_nxt;
  logic [lfsa_pkg::TOTAL_W-1:0]  total_r, total_nxt;
  logic                          valid_r;
  lfsa_pkg::lfsa_item_t          item_r, item_nxt;
  logic [IDX_W-1:0]              idx_r, idx_nxt;

  logic                          active;
  logic                          busy_hold;
  logic                          take;
  logic [lfsa_pkg::TOTAL_W:0]    sum;
  logic [lfsa_pkg::TOTAL_W-1:0]  sat_total;

  // slot is usable only below the configured count
  assign active = CMP_W'(CELL_IDX) < CMP_W'(slot_count);

  // lease expiry, then claim if nobody upstream took the request
  always_comb begin
    busy_hold = busy_r && (rel_r > lfsa_pkg::REL_W'(item_i.req_time));
    take      = valid_i && !item_i.granted && active && !busy_hold;
    sum       = {1'b0, total_r} + (lfsa_pkg::TOTAL_W + 1)'(item_i.amount);
    sat_total = sum[lfsa_pkg::TOTAL_W] ? lfsa_pkg::TOTAL_MAX : sum[lfsa_pkg::TOTAL_W-1:0];

    busy_nxt  = valid_i ? (take || busy_hold) : busy_r;
    rel_nxt   = take ? lfsa_pkg::REL_W'(item_i.req_time) + lfsa_pkg::REL_W'(item_i.hold_time)
                     : rel_r;
    total_nxt = take ? sat_total : total_r;

    item_nxt  = item_i;
    idx_nxt   = idx_i;
    if (take) begin
      item_nxt.granted    = 1'b1;
      item_nxt.slot_total = sat_total;
      idx_nxt             = IDX_W'(CELL_IDX);
    end
  end

  // control and totals reset; lease time and stage payload do not
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      total_r <= '0;
      valid_r <= 1'b0;
    end else if (en) begin
      busy_r  <= busy_nxt;
      total_r <= total_nxt;
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rel_r  <= rel_nxt;
      item_r <= item_nxt;
      idx_r  <= idx_nxt;
    end
  end

  assign valid_o = valid_r;
  assign item_o  = item_r;
  assign idx_o   = idx_r;

  // a request granted upstream passes through untouched
  a_keep_grant: assert property (@(posedge clk) disable iff (!rst_n)
    en && valid_i && item_i.granted |=> item_r.granted && idx_r == $past(idx_i))
    else $error("cell altered an upstream grant");

  // a claim leaves the slot leased
  a_claim_busy: assert property (@(posedge clk) disable iff (!rst_n)
    en && take |=> busy_r)
    else $error("claimed slot not marked busy");

  // an expired lease with no claim frees the slot
  a_expire_free: assert property (@(posedge clk) disable iff (!rst_n)
    en && valid_i && busy_r && !busy_hold && !take |=> !busy_r)
    else $error("expired lease not freed");

endmodule
